FILE: hdl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared codes, field widths and the memory control bundle of the broadcast
// ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DATA_W = 32;
  localparam int ID_W   = 2;
  localparam int SLOT_W = 2;
  localparam int STAT_W = 2;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic word_we;
    logic count_we;
  } mem_ctl_t;

endpackage

FILE: hdl/broadcast_ring_buffer.sv
// ----------------------------------------------------------------------------
// broadcast_ring_buffer
// Ring buffer with one writer and several readers, each of which reads every
// word. Refused commands report a status code and leave the state unchanged.
// The done strobe follows the start transfer through the busy state and the
// done register, and is high for exactly one cycle. A new command is taken
// only while not busy, since the slot entry is read, modified and written
// back through the registered memory read port.
// Reset clears the pointers, counters and strobe; the slot memories are not
// cleared.
// ----------------------------------------------------------------------------
module broadcast_ring_buffer #(
  parameter int DEPTH   = 4,
  parameter int READERS = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd,
  input  logic [brb_pkg::ID_W-1:0]   reader_id,
  input  logic [brb_pkg::DATA_W-1:0] write_data,
  output logic                       done,
  output brb_pkg::status_t           status,
  output logic [brb_pkg::DATA_W-1:0] read_data,
  output logic [brb_pkg::SLOT_W-1:0] slot
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(READERS + 1);
  localparam int UW = $clog2(DEPTH + 1);

  brb_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic [brb_pkg::DATA_W-1:0] wr_word;
  logic [CW-1:0]              wr_count;
  logic [brb_pkg::DATA_W-1:0] rd_word;
  logic [CW-1:0]              rd_count;

  brb_slot_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_word  (wr_word),
    .wr_count (wr_count),
    .rd_word  (rd_word),
    .rd_count (rd_count)
  );

  brb_ctrl #(
    .DEPTH   (DEPTH),
    .READERS (READERS),
    .AW      (AW),
    .CW      (CW),
    .UW      (UW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .reader_id  (reader_id),
    .write_data (write_data),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_word    (wr_word),
    .wr_count   (wr_count),
    .rd_word    (rd_word),
    .rd_count   (rd_count),
    .done       (done),
    .status     (status),
    .read_data  (read_data),
    .slot       (slot)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("start transfer did not make the block busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("busy cycle not followed by a single result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != brb_pkg::STATUS_DONE) |-> (read_data == '0))
    else $error("refused command returned data");

endmodule

FILE: hdl/brb_slot_mem.sv
// ----------------------------------------------------------------------------
// brb_slot_mem
// Slot storage: one memory for the words and one for the per-slot read
// counts, each with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brb_slot_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int CW    = 2
) (
  input  logic                       clk,
  input  brb_pkg::mem_ctl_t          ctl,
  input  logic [AW-1:0]              rd_addr,
  input  logic [AW-1:0]              wr_addr,
  input  logic [brb_pkg::DATA_W-1:0] wr_word,
  input  logic [CW-1:0]              wr_count,
  output logic [brb_pkg::DATA_W-1:0] rd_word,
  output logic [CW-1:0]              rd_count
);

  logic [brb_pkg::DATA_W-1:0] words  [DEPTH];
  logic [CW-1:0]              counts [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.word_we) begin
      words[wr_addr] <= wr_word;
    end
    if (ctl.rd_en) begin
      rd_word <= words[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.count_we) begin
      counts[wr_addr] <= wr_count;
    end
    if (ctl.rd_en) begin
      rd_count <= counts[rd_addr];
    end
  end

endmodule

FILE: hdl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Command sequencer: holds the pointers and counters, issues the slot read on
// a start transfer and performs the update and write-back in the cycle after it.
// ----------------------------------------------------------------------------
module brb_ctrl #(
  parameter int DEPTH   = 4,
  parameter int READERS = 3,
  parameter int AW      = 2,
  parameter int CW      = 2,
  parameter int UW      = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd,
  input  logic [brb_pkg::ID_W-1:0]   reader_id,
  input  logic [brb_pkg::DATA_W-1:0] write_data,
  output brb_pkg::mem_ctl_t          mem_ctl,
  output logic [AW-1:0]              rd_addr,
  output logic [AW-1:0]              wr_addr,
  output logic [brb_pkg::DATA_W-1:0] wr_word,
  output logic [CW-1:0]              wr_count,
  input  logic [brb_pkg::DATA_W-1:0] rd_word,
  input  logic [CW-1:0]              rd_count,
  output logic                       done,
  output brb_pkg::status_t           status,
  output logic [brb_pkg::DATA_W-1:0] read_data,
  output logic [brb_pkg::SLOT_W-1:0] slot
);

  localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int PW = (AW > brb_pkg::SLOT_W) ? AW : brb_pkg::SLOT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                       state;
  logic                       op_cmd;
  logic                       op_ok;
  logic [RW-1:0]              op_idx;
  logic [brb_pkg::DATA_W-1:0] op_data;
  logic [AW-1:0]              op_ptr;
  logic [AW-1:0]              write_ptr;
  logic [UW-1:0]              free_slots;
  logic [AW-1:0]              reader_ptr [READERS];
  logic [UW-1:0]              unread     [READERS];

  logic                       accept;
  logic                       sel_ok;
  logic [RW-1:0]              sel_idx;
  logic [AW-1:0]              sel_ptr;
  logic                       wr_go;
  logic                       rd_go;
  logic [CW-1:0]              count_next;
  logic [AW-1:0]              ptr_next;
  logic [PW-1:0]              slot_wide;

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;

  always_comb begin
    sel_ok  = 1'b0;
    sel_idx = '0;
    sel_ptr = '0;
    for (int r = 0; r < READERS; r++) begin
      if (int'(reader_id) == r) begin
        sel_ok  = 1'b1;
        sel_idx = RW'(r);
        sel_ptr = reader_ptr[r];
      end
    end
  end

  assign rd_addr = (cmd == brb_pkg::CMD_WRITE) ? write_ptr : sel_ptr;

  assign wr_go = busy && (op_cmd == brb_pkg::CMD_WRITE) && (free_slots != '0);
  assign rd_go = busy && (op_cmd == brb_pkg::CMD_READ) && op_ok && (unread[op_idx] != '0);

  assign count_next = rd_count + CW'(1);
  assign ptr_next   = (op_ptr == AW'(DEPTH - 1)) ? '0 : op_ptr + AW'(1);
  assign slot_wide  = PW'(op_ptr);

  always_comb begin
    mem_ctl.rd_en    = accept;
    mem_ctl.word_we  = wr_go;
    mem_ctl.count_we = wr_go || rd_go;
  end

  assign wr_addr  = op_ptr;
  assign wr_word  = op_data;
  assign wr_count = wr_go ? '0 : count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      write_ptr  <= '0;
      free_slots <= UW'(DEPTH);
      for (int r = 0; r < READERS; r++) begin
        reader_ptr[r] <= '0;
        unread[r]     <= '0;
      end
    end else begin
      done <= busy;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          if (wr_go) begin
            write_ptr  <= ptr_next;
            free_slots <= free_slots - UW'(1);
            for (int r = 0; r < READERS; r++) begin
              unread[r] <= unread[r] + UW'(1);
            end
          end
          if (rd_go) begin
            unread[op_idx]     <= unread[op_idx] - UW'(1);
            reader_ptr[op_idx] <= ptr_next;
            if ((int'(count_next) == READERS) && (free_slots < UW'(DEPTH))) begin
              free_slots <= free_slots + UW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd  <= cmd;
      op_ok   <= sel_ok;
      op_idx  <= sel_idx;
      op_data <= write_data;
      op_ptr  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      slot      <= slot_wide[brb_pkg::SLOT_W-1:0];
      read_data <= rd_go ? rd_word : '0;
      if (wr_go || rd_go) begin
        status <= brb_pkg::STATUS_DONE;
      end else if (op_cmd == brb_pkg::CMD_WRITE) begin
        status <= brb_pkg::STATUS_FULL;
      end else begin
        status <= brb_pkg::STATUS_EMPTY;
      end
    end
  end

endmodule
